// File: design/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by pse_alu and postfix_stack_evaluator; depends on nothing.
package pse_pkg;

  localparam int DATA_W      = 32;
  localparam int CODE_W      = 3;
  localparam int DEPTH_OUT_W = 7;

  localparam logic [CODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [CODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [CODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [CODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [CODE_W-1:0] OP_DIV  = 3'd4;

  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] code;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              bad;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: design/pse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pse_alu.sv
// Shared arithmetic unit: registered add, subtract, multiply and an iterative
// radix-2 divide of a signed value by a positive divisor. Depends on pse_pkg.
module pse_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  pse_pkg::alu_req_t       req,
  input  logic [pse_pkg::DATA_W-1:0] left,
  input  logic [pse_pkg::DATA_W-1:0] right,
  output pse_pkg::alu_rsp_t       rsp
);
  import pse_pkg::*;

  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic              done;
  logic              bad;
  logic [DATA_W-1:0] result;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvsr;
  logic              neg;

  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] quo_next;

  always_comb begin
    shifted = {rem[DATA_W-2:0], quo[DATA_W-1]};
    if (shifted >= dvsr) begin
      rem_next = shifted - dvsr;
      quo_next = {quo[DATA_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quo[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        bad <= 1'b0;
        case (req.code)
          OP_ADD: begin
            result <= left + right;
            done   <= 1'b1;
          end
          OP_SUB: begin
            result <= left - right;
            done   <= 1'b1;
          end
          OP_MUL: begin
            result <= left * right;
            done   <= 1'b1;
          end
          OP_DIV: begin
            if (right[DATA_W-1] || right == '0) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              busy  <= 1'b1;
              count <= '0;
              rem   <= '0;
              quo   <= left[DATA_W-1] ? (~left + 1'b1) : left;
              neg   <= left[DATA_W-1];
              dvsr  <= right;
            end
          end
          default: begin
            result <= '0;
            bad    <= 1'b1;
            done   <= 1'b1;
          end
        endcase
      end else if (busy) begin
        if (count == CNT_W'(DIV_STEPS)) begin
          // apply sign after the last step
          result <= neg ? (~quo + 1'b1) : quo;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else begin
          rem   <= rem_next;
          quo   <= quo_next;
          count <= count + 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.bad    = bad;
  assign rsp.result = result;

endmodule

// File: design/postfix_stack_evaluator.sv
// Postfix (RPN) expression evaluator on an operand stack held in RAM.
// Depends on pse_pkg, pse_ram and pse_alu.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    opcode, operand_value
//   out       out_valid / out_ready  top_value, stack_depth, underflow,
//                                    overflow, bad_operator
//
// A push goes from acceptance to ST_DONE; operators pass ST_EXEC, ST_WAIT and
// ST_DONE; divide waits in ST_WAIT for the 32 steps of the radix-2 divider.
// One item is in work at a time; in_ready is high only in the idle state.
// The result register holds a finished item while the next one is accepted;
// a later item waits for that register before it is delivered.
// Reset empties the stack; stack entries are not cleared.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pse_pkg::CODE_W-1:0]       opcode,
  input  logic signed [pse_pkg::DATA_W-1:0] operand_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [pse_pkg::DATA_W-1:0] top_value,
  output logic [pse_pkg::DEPTH_OUT_W-1:0]  stack_depth,
  output logic                             underflow,
  output logic                             overflow,
  output logic                             bad_operator
);
  import pse_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t            state;
  logic [CW-1:0]     depth;
  logic [DATA_W-1:0] top;
  logic [CODE_W-1:0] code;
  logic              under;
  logic              over;
  logic              bad;

  logic              accept;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic [CW-1:0]     depth_next;
  logic              has_two;
  logic              has_one;
  logic              full;
  logic [DATA_W-1:0] alu_left;
  logic [DATA_W-1:0] alu_right;
  alu_req_t          req;
  alu_rsp_t          rsp;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign has_two  = depth > CW'(1);
  assign has_one  = depth != '0;
  assign full     = depth >= CW'(STACK_DEPTH);
  assign raddr    = AW'(depth - CW'(2));

  // pop two, push one: never below one entry after an operator
  assign depth_next = has_two ? (depth - 1'b1) : CW'(1);

  assign alu_left  = has_two ? rdata : '0;
  assign alu_right = has_one ? top : '0;
  assign req.start = (state == ST_EXEC);
  assign req.code  = code;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(depth);
    wdata = DATA_W'(operand_value);
    if (accept && opcode == OP_PUSH && !full) begin
      we = 1'b1;
    end else if (state == ST_WAIT && rsp.done) begin
      we    = 1'b1;
      waddr = AW'(depth_next - 1'b1);
      wdata = rsp.result;
    end
  end

  pse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  pse_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .left (alu_left),
    .right(alu_right),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            code  <= opcode;
            under <= 1'b0;
            bad   <= 1'b0;
            over  <= 1'b0;
            if (opcode == OP_PUSH) begin
              if (full) begin
                over <= 1'b1;
              end else begin
                top   <= DATA_W'(operand_value);
                depth <= depth + 1'b1;
              end
              state <= ST_DONE;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          under <= !has_two;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (rsp.done) begin
            top   <= rsp.result;
            depth <= depth_next;
            bad   <= rsp.bad;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            top_value    <= has_one ? top : '0;
            stack_depth  <= DEPTH_OUT_W'(depth);
            underflow    <= under;
            overflow     <= over;
            bad_operator <= bad;
            state        <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
